FILE: src/gcat_pkg.sv
// ----------------------------------------------------------------------------
// gcat_pkg
// Shared constants, codes and types of the guarded change admission table.
// ----------------------------------------------------------------------------
package gcat_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int SLOT_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   localparam int  CSR_ADDR_W = 3;
   localparam int  CSR_DATA_W = 32;
   localparam logic [30:0] BUDGET_RESET = 31'd240;
   localparam logic [7:0]  HYST_RESET   = 8'd2;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      RSN_OK       = 3'd0,
      RSN_NO_ENTRY = 3'd1,
      RSN_PEAK     = 3'd2,
      RSN_BUDGET   = 3'd3,
      RSN_HYST     = 3'd4
   } reason_type;

   typedef enum logic {
      CSR_CHANGE_BUDGET   = 1'b0,
      CSR_HYSTERESIS_STEP = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type             operation;
      logic [3:0]         entry_index;
      logic               has_channel;
      logic [7:0]         target_channel;
      logic               has_power;
      logic signed [7:0]  new_power;
      logic               urgent;
      logic               in_peak;
      logic signed [31:0] current_time;
   } req_type;

   typedef struct packed {
      logic               accepted;
      reason_type         reason;
      logic               changed;
      logic [7:0]         channel_now;
      logic signed [7:0]  power_now;
      logic signed [31:0] last_change_now;
   } rsp_type;

endpackage

FILE: src/gcat_intf.sv
// ----------------------------------------------------------------------------
// gcat request and response channels
// Valid/ready channels carrying one request beat or one response beat.
// ----------------------------------------------------------------------------
interface gcat_req_if
   import gcat_pkg::*;
   ();
   logic               valid;
   logic               ready;
   op_type             operation;
   logic [3:0]         entry_index;
   logic               has_channel;
   logic [7:0]         target_channel;
   logic               has_power;
   logic signed [7:0]  new_power;
   logic               urgent;
   logic               in_peak;
   logic signed [31:0] current_time;

   modport source (
      output valid, operation, entry_index, has_channel, target_channel,
             has_power, new_power, urgent, in_peak, current_time,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, has_channel, target_channel,
             has_power, new_power, urgent, in_peak, current_time,
      output ready
   );
endinterface

interface gcat_rsp_if
   import gcat_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               accepted;
   reason_type         reason;
   logic               changed;
   logic [7:0]         channel_now;
   logic signed [7:0]  power_now;
   logic signed [31:0] last_change_now;

   modport source (
      output valid, accepted, reason, changed, channel_now, power_now,
             last_change_now,
      input  ready
   );
   modport sink (
      input  valid, accepted, reason, changed, channel_now, power_now,
             last_change_now,
      output ready
   );
endinterface

FILE: src/guarded_change_admission_table_top.sv
// ----------------------------------------------------------------------------
// guarded_change_admission_table_top
// Entry table with load and guarded change requests; one response per beat.
// ----------------------------------------------------------------------------
// A request beat is taken into the input register; its response is registered
// in the response register once that register is empty or its response is
// taken. Throughput: one beat per cycle while responses are taken, set by the
// single read-check-write pass over the entry table between those registers.
// Reset clears the entry valid bits, both pipeline stages and the CSRs (to
// their default values); entry contents are left as they are.
module guarded_change_admission_table_top
   import gcat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   gcat_req_if.sink              req,
   gcat_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // CSRs
   logic [30:0]   budget_ff;
   logic [7:0]    hyst_ff;
   logic          csr_write;
   csr_index_type csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         hyst_ff   <= HYST_RESET;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_CHANGE_BUDGET:   budget_ff <= pwdata[30:0];
            CSR_HYSTERESIS_STEP: hyst_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_CHANGE_BUDGET:   prdata = {1'b0, budget_ff};
         CSR_HYSTERESIS_STEP: prdata = {24'd0, hyst_ff};
         default:             prdata = '0;
      endcase
   end

   // Input register and response register
   logic    s1_valid_ff;
   req_type s1_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    advance;
   logic    req_take;
   req_type req_in;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   assign req_in = '{
      operation:      req.operation,
      entry_index:    req.entry_index,
      has_channel:    req.has_channel,
      target_channel: req.target_channel,
      has_power:      req.has_power,
      new_power:      req.new_power,
      urgent:         req.urgent,
      in_peak:        req.in_peak,
      current_time:   req.current_time
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= req_in;
      end
   end

   // Entry table
   logic [NUM_ENTRIES-1:0] valid_ff;
   logic [7:0]             chan_ff [NUM_ENTRIES];
   logic signed [7:0]      pwr_ff  [NUM_ENTRIES];
   logic signed [31:0]     last_ff [NUM_ENTRIES];

   logic [31:0]        idx_wide;
   logic [SLOT_W-1:0]  slot;
   logic               in_range;
   logic               hit;
   logic [7:0]         cur_chan;
   logic signed [7:0]  cur_pwr;
   logic signed [31:0] cur_last;

   assign idx_wide = 32'(s1_ff.entry_index);
   assign slot     = idx_wide[SLOT_W-1:0];
   assign in_range = idx_wide < 32'(NUM_ENTRIES);
   assign hit      = in_range && valid_ff[slot];
   assign cur_chan = chan_ff[slot];
   assign cur_pwr  = pwr_ff[slot];
   assign cur_last = last_ff[slot];

   // Admission checks
   logic signed [32:0] since;
   logic signed [8:0]  pwr_diff;
   logic [7:0]         pwr_mag;
   logic               budget_short;
   logic               hyst_short;
   logic               chan_moves;
   logic               pwr_moves;
   logic               is_load;
   reason_type         req_reason;

   assign since        = 33'(s1_ff.current_time) - 33'(cur_last);
   assign budget_short = since < $signed({2'b00, budget_ff});
   assign pwr_diff     = 9'(s1_ff.new_power) - 9'(cur_pwr);
   assign pwr_mag      = pwr_diff[8] ? 8'(-pwr_diff) : pwr_diff[7:0];
   assign hyst_short   = s1_ff.has_power && (pwr_mag < hyst_ff);
   assign chan_moves   = s1_ff.has_channel && (cur_chan != s1_ff.target_channel);
   assign pwr_moves    = s1_ff.has_power && (cur_pwr != s1_ff.new_power);
   assign is_load      = s1_ff.operation == OP_LOAD;

   always_comb begin
      if (!hit) begin
         req_reason = RSN_NO_ENTRY;
      end else if (s1_ff.in_peak && !s1_ff.urgent) begin
         req_reason = RSN_PEAK;
      end else if (budget_short) begin
         req_reason = RSN_BUDGET;
      end else if (hyst_short) begin
         req_reason = RSN_HYST;
      end else begin
         req_reason = RSN_OK;
      end
   end

   // Entry update and response
   logic               write_en;
   logic               valid_set;
   logic [7:0]         chan_in;
   logic signed [7:0]  pwr_in;
   logic signed [31:0] last_in;
   rsp_type            rsp_in;

   always_comb begin
      write_en = 1'b0;
      valid_set = 1'b0;
      chan_in = cur_chan;
      pwr_in  = cur_pwr;
      last_in = cur_last;
      rsp_in  = '{accepted: 1'b0, reason: RSN_NO_ENTRY, changed: 1'b0,
                  channel_now: 8'd0, power_now: 8'sd0, last_change_now: 32'sd0};
      if (!in_range) begin
         // An index past the table is answered as a missing entry.
         rsp_in.reason = RSN_NO_ENTRY;
      end else if (is_load) begin
         write_en  = 1'b1;
         valid_set = 1'b1;
         chan_in   = s1_ff.target_channel;
         pwr_in    = s1_ff.new_power;
         last_in   = s1_ff.current_time;
         rsp_in = '{accepted: 1'b1, reason: RSN_OK, changed: 1'b0,
                    channel_now: chan_in, power_now: pwr_in,
                    last_change_now: last_in};
      end else if (req_reason == RSN_NO_ENTRY) begin
         rsp_in.reason = RSN_NO_ENTRY;
      end else if (req_reason != RSN_OK) begin
         rsp_in = '{accepted: 1'b0, reason: req_reason, changed: 1'b0,
                    channel_now: cur_chan, power_now: cur_pwr,
                    last_change_now: cur_last};
      end else begin
         write_en = 1'b1;
         if (chan_moves) begin
            chan_in = s1_ff.target_channel;
         end
         if (pwr_moves) begin
            pwr_in = s1_ff.new_power;
         end
         if (chan_moves || pwr_moves) begin
            last_in = s1_ff.current_time;
         end
         rsp_in = '{accepted: 1'b1, reason: RSN_OK,
                    changed: chan_moves || pwr_moves,
                    channel_now: chan_in, power_now: pwr_in,
                    last_change_now: last_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance && valid_set) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write_en) begin
         chan_ff[slot] <= chan_in;
         pwr_ff[slot]  <= pwr_in;
         last_ff[slot] <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.accepted        = rsp_ff.accepted;
   assign rsp.reason          = rsp_ff.reason;
   assign rsp.changed         = rsp_ff.changed;
   assign rsp.channel_now     = rsp_ff.channel_now;
   assign rsp.power_now       = rsp_ff.power_now;
   assign rsp.last_change_now = rsp_ff.last_change_now;

   // Checks
   a_accept_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.accepted == (rsp_ff.reason == RSN_OK)))
      else $error("accepted flag disagrees with reason");

   a_reject_unchanged: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.accepted) |-> !rsp_ff.changed)
      else $error("rejected beat reports a change");

   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.reason == RSN_NO_ENTRY) |->
         (rsp_ff.channel_now == 8'd0 && rsp_ff.power_now == 8'sd0 &&
          rsp_ff.last_change_now == 32'sd0))
      else $error("missing entry reports contents");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_set) |=> valid_ff[$past(slot)])
      else $error("load did not mark the entry valid");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff && valid_ff == '0))
      else $error("pipeline or table not cleared by reset");

endmodule
